@@ design/tmls_pkg.sv @@
// ----------------------------------------------------------------------------
// tmls_pkg
// Shared widths, register map, reset values and codes for the trimmed-mean
// load scaler.
// ----------------------------------------------------------------------------
package tmls_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int COUNT_W     = 7;
	localparam int OFFSET_W    = 24;
	localparam int SCALE_W     = 32;
	localparam int LOAD_W      = 32;
	localparam int MEAN_W      = 31;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;
	localparam int REG_IDX_W   = ADDR_W - 2;
	localparam int MAX_SAMPLES = 64;
	localparam int ALU_W       = SCALE_W + 1;

	localparam logic [REG_IDX_W-1:0] REG_COUNT  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SCALE  = 2'd2;

	localparam logic [COUNT_W-1:0]  COUNT_RST  = 7'd10;
	localparam logic [OFFSET_W-1:0] OFFSET_RST = 24'd0;
	localparam logic [SCALE_W-1:0]  SCALE_RST  = 32'h0100_0000;

	localparam logic [LOAD_W-1:0] LOAD_FAULT   = 32'hFFFF_0000;
	localparam logic [LOAD_W-1:0] LOAD_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [LOAD_W-1:0] LOAD_NEG_MAX = 32'h8000_0000;

	localparam logic MODE_DIV = 1'b0;
	localparam logic MODE_MUL = 1'b1;

	typedef struct packed {
		logic start;
		logic mode;
	} iter_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_stat_t;

endpackage

@@ design/tmls_accum.sv @@
// ----------------------------------------------------------------------------
// tmls_accum
// Per-block statistics: running sum, min/max with hit counts, sample count
// and sticky fault. Flags the beat that closes a block.
// ----------------------------------------------------------------------------
module tmls_accum #(
	parameter int MAX_SAMPLES = tmls_pkg::MAX_SAMPLES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic                                 clear,
	input  logic signed [tmls_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 sample_fault,
	input  logic [tmls_pkg::COUNT_W-1:0]         cfg_count,
	output logic                                 block_end,
	output logic signed [tmls_pkg::SAMPLE_W+$clog2(MAX_SAMPLES+1)-1:0] sum,
	output logic signed [tmls_pkg::SAMPLE_W-1:0] bmin,
	output logic signed [tmls_pkg::SAMPLE_W-1:0] bmax,
	output logic [$clog2(MAX_SAMPLES+1)-1:0]     min_hits,
	output logic [$clog2(MAX_SAMPLES+1)-1:0]     max_hits,
	output logic [$clog2(MAX_SAMPLES+1)-1:0]     seen,
	output logic                                 fault_seen
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = tmls_pkg::SAMPLE_W + CNT_W;

	logic [CNT_W-1:0]                     target;
	logic [CNT_W:0]                       seen_inc;
	logic                                 first;
	logic signed [SUM_W-1:0]              sum_q;
	logic signed [tmls_pkg::SAMPLE_W-1:0] bmin_q;
	logic signed [tmls_pkg::SAMPLE_W-1:0] bmax_q;
	logic [CNT_W-1:0]                     min_hits_q;
	logic [CNT_W-1:0]                     max_hits_q;
	logic [CNT_W-1:0]                     seen_q;
	logic                                 fault_q;

	// zero acts as one, oversize clamps to the maximum
	always_comb begin
		if (cfg_count == '0) begin
			target = CNT_W'(1);
		end else if (int'(cfg_count) > MAX_SAMPLES) begin
			target = CNT_W'(MAX_SAMPLES);
		end else begin
			target = CNT_W'(cfg_count);
		end
	end

	assign seen_inc  = {1'b0, seen_q} + (CNT_W+1)'(1);
	assign block_end = seen_inc >= {1'b0, target};
	assign first     = seen_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			min_hits_q <= '0;
			max_hits_q <= '0;
			seen_q     <= '0;
			fault_q    <= 1'b0;
		end else if (clear) begin
			sum_q      <= '0;
			min_hits_q <= '0;
			max_hits_q <= '0;
			seen_q     <= '0;
			fault_q    <= 1'b0;
		end else if (accept) begin
			sum_q   <= sum_q + SUM_W'(sample);
			seen_q  <= seen_inc[CNT_W-1:0];
			fault_q <= fault_q | sample_fault;
			if (first) begin
				min_hits_q <= CNT_W'(1);
				max_hits_q <= CNT_W'(1);
			end else begin
				if (sample < bmin_q) begin
					min_hits_q <= CNT_W'(1);
				end else if (sample == bmin_q) begin
					min_hits_q <= min_hits_q + CNT_W'(1);
				end
				if (sample > bmax_q) begin
					max_hits_q <= CNT_W'(1);
				end else if (sample == bmax_q) begin
					max_hits_q <= max_hits_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (first || sample < bmin_q) begin
				bmin_q <= sample;
			end
			if (first || sample > bmax_q) begin
				bmax_q <= sample;
			end
		end
	end

	assign sum        = sum_q;
	assign bmin       = bmin_q;
	assign bmax       = bmax_q;
	assign min_hits   = min_hits_q;
	assign max_hits   = max_hits_q;
	assign seen       = seen_q;
	assign fault_seen = fault_q;

endmodule

@@ design/tmls_iter.sv @@
// ----------------------------------------------------------------------------
// tmls_iter
// Shared add/subtract unit stepped one bit a cycle: restoring division of
// the kept sum by the kept count, or shift-add multiply for the scaling.
// ----------------------------------------------------------------------------
module tmls_iter #(
	parameter int MAX_SAMPLES = tmls_pkg::MAX_SAMPLES
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tmls_pkg::iter_cmd_t                    cmd,
	input  logic [tmls_pkg::SAMPLE_W+$clog2(MAX_SAMPLES+1)+6:0] dividend,
	input  logic [$clog2(MAX_SAMPLES+1)-1:0]       divisor,
	input  logic [tmls_pkg::SCALE_W-1:0]           mcand,
	input  logic [tmls_pkg::SCALE_W-1:0]           mplier,
	output tmls_pkg::iter_stat_t                   stat,
	output logic [tmls_pkg::SAMPLE_W+$clog2(MAX_SAMPLES+1)+6:0] quotient,
	output logic [2*tmls_pkg::SCALE_W-1:0]         product
);

	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int DW     = tmls_pkg::SAMPLE_W + CNT_W + 7;
	localparam int OP_W   = tmls_pkg::SCALE_W;
	localparam int ALU_W  = tmls_pkg::ALU_W;
	localparam int STEP_W = $clog2(DW + 1);

	logic [OP_W-1:0]   hi_q;
	logic [DW-1:0]     lo_q;
	logic [OP_W-1:0]   opnd_q;
	logic              mode_q;
	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [STEP_W-1:0] last;

	logic [CNT_W:0]    trial;
	logic [ALU_W-1:0]  alu_a;
	logic [ALU_W-1:0]  alu_b;
	logic              alu_sub;
	logic [ALU_W-1:0]  alu_y;
	logic              neg;

	assign trial = {hi_q[CNT_W-1:0], lo_q[DW-1]};

	always_comb begin
		if (mode_q == tmls_pkg::MODE_DIV) begin
			alu_a   = ALU_W'(trial);
			alu_b   = ALU_W'(opnd_q);
			alu_sub = 1'b1;
		end else begin
			alu_a   = ALU_W'(hi_q);
			alu_b   = lo_q[0] ? ALU_W'(opnd_q) : '0;
			alu_sub = 1'b0;
		end
		alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
	end

	assign neg  = alu_y[ALU_W-1];
	assign last = (mode_q == tmls_pkg::MODE_DIV) ? STEP_W'(DW - 1) : STEP_W'(OP_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !cmd.start && busy_q && (cnt_q == last);
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= cmd.mode;
			hi_q   <= '0;
			if (cmd.mode == tmls_pkg::MODE_DIV) begin
				lo_q   <= dividend;
				opnd_q <= OP_W'(divisor);
			end else begin
				lo_q   <= DW'(mplier);
				opnd_q <= mcand;
			end
		end else if (busy_q) begin
			if (mode_q == tmls_pkg::MODE_DIV) begin
				hi_q <= OP_W'(neg ? trial[CNT_W-1:0] : alu_y[CNT_W-1:0]);
				lo_q <= {lo_q[DW-2:0], ~neg};
			end else begin
				hi_q <= alu_y[ALU_W-1:1];
				lo_q <= {lo_q[DW-1:OP_W], alu_y[0], lo_q[OP_W-1:1]};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = lo_q;
	assign product   = {hi_q, lo_q[OP_W-1:0]};

endmodule

@@ design/trimmed_mean_load_scaler.sv @@
// ----------------------------------------------------------------------------
// trimmed_mean_load_scaler
// Block-averages load-cell samples with min/max rejection and scales the
// trimmed mean to a Q16.16 load.
//
//   channel   signals                                   handshake
//   sample    sample, sample_fault                      sample_valid / sample_stall
//   result    load, mean_counts, fault                  result_valid / result_stall
//   config    psel, penable, pwrite, paddr, pwdata,     APB, pready tied high
//             prdata
//
// A beat that does not close a block is taken without a stall. A closing
// beat runs the trim steps, then a division of DW = 31 + clog2(MAX_SAMPLES+1)
// quotient bits and a multiply on the shared add/subtract unit: one quotient
// bit, then one product bit, per cycle. With nothing to divide the division
// is skipped. A faulted block goes from the min trim step straight to output.
// sample_stall is high while a block closes; a result waits in the output
// register under result_stall while the next block is collected.
// Reset is asynchronous; it clears the block sum, hit counts, sample count
// and fault, and returns the configuration and the control state to reset.
// ----------------------------------------------------------------------------
module trimmed_mean_load_scaler #(
	parameter int MAX_SAMPLES = tmls_pkg::MAX_SAMPLES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [tmls_pkg::ADDR_W-1:0]          paddr,
	input  logic [tmls_pkg::DATA_W-1:0]          pwdata,
	output logic [tmls_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [tmls_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 sample_fault,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [tmls_pkg::LOAD_W-1:0]   load,
	output logic [tmls_pkg::MEAN_W-1:0]          mean_counts,
	output logic                                 fault
);

	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = tmls_pkg::SAMPLE_W + CNT_W;
	localparam int KS_W   = SUM_W + 1;
	localparam int DW     = SUM_W + 7;
	localparam int ALU_W  = tmls_pkg::ALU_W;
	localparam int OP_W   = tmls_pkg::SCALE_W;
	localparam int Q_W    = 2 * OP_W - 16;
	localparam int MEAN_W = tmls_pkg::MEAN_W;
	localparam int LOAD_W = tmls_pkg::LOAD_W;
	localparam int OFF_W  = tmls_pkg::OFFSET_W;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_TRIM_MIN = 3'd1;
	localparam logic [2:0] ST_TRIM_MAX = 3'd2;
	localparam logic [2:0] ST_CHECK    = 3'd3;
	localparam logic [2:0] ST_DIV_WAIT = 3'd4;
	localparam logic [2:0] ST_SCALE    = 3'd5;
	localparam logic [2:0] ST_MUL_WAIT = 3'd6;
	localparam logic [2:0] ST_FIN      = 3'd7;

	// configuration
	logic [tmls_pkg::COUNT_W-1:0] count_q;
	logic [OFF_W-1:0]             offset_q;
	logic [tmls_pkg::SCALE_W-1:0] scale_q;
	logic [tmls_pkg::REG_IDX_W-1:0] reg_idx;

	assign reg_idx = paddr[tmls_pkg::ADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= tmls_pkg::COUNT_RST;
			offset_q <= tmls_pkg::OFFSET_RST;
			scale_q  <= tmls_pkg::SCALE_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				tmls_pkg::REG_COUNT:  count_q  <= pwdata[tmls_pkg::COUNT_W-1:0];
				tmls_pkg::REG_OFFSET: offset_q <= pwdata[OFF_W-1:0];
				tmls_pkg::REG_SCALE:  scale_q  <= pwdata[tmls_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tmls_pkg::REG_COUNT:  prdata = tmls_pkg::DATA_W'(count_q);
			tmls_pkg::REG_OFFSET: prdata = tmls_pkg::DATA_W'(offset_q);
			tmls_pkg::REG_SCALE:  prdata = tmls_pkg::DATA_W'(scale_q);
			default:              prdata = '0;
		endcase
	end

	// sequencer and datapath
	logic [2:0] state_q;
	logic       accept;
	logic       out_free;
	logic       fin_go;

	logic                                 acc_end;
	logic signed [SUM_W-1:0]              acc_sum;
	logic signed [tmls_pkg::SAMPLE_W-1:0] acc_min;
	logic signed [tmls_pkg::SAMPLE_W-1:0] acc_max;
	logic [CNT_W-1:0]                     acc_min_hits;
	logic [CNT_W-1:0]                     acc_max_hits;
	logic [CNT_W-1:0]                     acc_seen;
	logic                                 acc_fault;

	tmls_pkg::iter_cmd_t  it_cmd;
	tmls_pkg::iter_stat_t it_stat;
	logic [DW-1:0]        it_dividend;
	logic [DW-1:0]        it_quotient;
	logic [2*OP_W-1:0]    it_product;
	logic [OP_W-1:0]      mag;

	logic signed [KS_W-1:0]  kept_q;
	logic [CNT_W-1:0]        kcnt_q;
	logic [MEAN_W-1:0]       mean_q;
	logic                    neg_q;
	logic                    trim;
	logic                    go_div;
	logic signed [KS_W-1:0]  trim_prod;
	logic signed [tmls_pkg::SAMPLE_W-1:0] tp_a;
	logic [CNT_W-1:0]        tp_b;

	logic [ALU_W-1:0] mean_ext;
	logic [ALU_W-1:0] offs_ext;
	logic [ALU_W-1:0] diff;
	logic [ALU_W-1:0] diff_mag;
	logic             diff_neg;

	logic [Q_W-1:0]    q;
	logic              q_big;
	logic [LOAD_W-1:0] load_d;

	logic [LOAD_W-1:0] load_q;
	logic [MEAN_W-1:0] mean_out_q;
	logic              fault_q;
	logic              valid_q;

	assign sample_stall = state_q != ST_IDLE;
	assign accept       = sample_valid && !sample_stall;
	assign out_free     = !valid_q || !result_stall;
	assign fin_go       = (state_q == ST_FIN) && out_free;

	tmls_accum #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.clear       (fin_go),
		.sample      (sample),
		.sample_fault(sample_fault),
		.cfg_count   (count_q),
		.block_end   (acc_end),
		.sum         (acc_sum),
		.bmin        (acc_min),
		.bmax        (acc_max),
		.min_hits    (acc_min_hits),
		.max_hits    (acc_max_hits),
		.seen        (acc_seen),
		.fault_seen  (acc_fault)
	);

	assign trim = (acc_seen > CNT_W'(2)) && (acc_min != acc_max);

	// one small multiplier, used for the min term then the max term
	assign tp_a      = (state_q == ST_TRIM_MIN) ? acc_min : acc_max;
	assign tp_b      = (state_q == ST_TRIM_MIN) ? acc_min_hits : acc_max_hits;
	assign trim_prod = KS_W'(tp_a) * KS_W'($signed({1'b0, tp_b}));

	assign go_div      = !kept_q[KS_W-1] && (kept_q != '0) && (kcnt_q != '0);
	assign it_dividend = {kept_q[SUM_W-2:0], 8'd0};

	always_comb begin
		mean_ext = {{(ALU_W-MEAN_W){1'b0}}, mean_q};
		offs_ext = {{(ALU_W-OFF_W-8){offset_q[OFF_W-1]}}, offset_q, 8'd0};
		diff     = mean_ext - offs_ext;
		diff_neg = diff[ALU_W-1];
		diff_mag = diff_neg ? (~diff + ALU_W'(1)) : diff;
		mag      = diff_mag[OP_W-1:0];
	end

	assign it_cmd.start = ((state_q == ST_CHECK) && go_div) || (state_q == ST_SCALE);
	assign it_cmd.mode  = (state_q == ST_SCALE) ? tmls_pkg::MODE_MUL : tmls_pkg::MODE_DIV;

	tmls_iter #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_iter (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (it_cmd),
		.dividend(it_dividend),
		.divisor (kcnt_q),
		.mcand   (mag),
		.mplier  (scale_q),
		.stat    (it_stat),
		.quotient(it_quotient),
		.product (it_product)
	);

	// Q.32 product down to Q16.16, saturated
	always_comb begin
		q     = it_product[2*OP_W-1:16];
		q_big = |q[Q_W-1:LOAD_W];
		if (acc_fault) begin
			load_d = tmls_pkg::LOAD_FAULT;
		end else if (neg_q) begin
			if (q_big || (q[LOAD_W-1] && |q[LOAD_W-2:0])) begin
				load_d = tmls_pkg::LOAD_NEG_MAX;
			end else begin
				load_d = ~q[LOAD_W-1:0] + LOAD_W'(1);
			end
		end else if (q_big || q[LOAD_W-1]) begin
			load_d = tmls_pkg::LOAD_POS_MAX;
		end else begin
			load_d = q[LOAD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && acc_end) begin
						state_q <= ST_TRIM_MIN;
					end
				end
				ST_TRIM_MIN: begin
					state_q <= acc_fault ? ST_FIN : ST_TRIM_MAX;
				end
				ST_TRIM_MAX: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= go_div ? ST_DIV_WAIT : ST_SCALE;
				end
				ST_DIV_WAIT: begin
					if (it_stat.done) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					state_q <= ST_MUL_WAIT;
				end
				ST_MUL_WAIT: begin
					if (it_stat.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_TRIM_MIN: begin
				if (trim) begin
					kept_q <= KS_W'(acc_sum) - trim_prod;
					kcnt_q <= acc_seen - acc_min_hits - acc_max_hits;
				end else if (acc_seen > CNT_W'(2)) begin
					kept_q <= '0;
					kcnt_q <= '0;
				end else begin
					kept_q <= KS_W'(acc_sum);
					kcnt_q <= acc_seen;
				end
			end
			ST_TRIM_MAX: begin
				if (trim) begin
					kept_q <= kept_q - trim_prod;
				end
			end
			ST_CHECK: begin
				if (!go_div) begin
					mean_q <= '0;
				end
			end
			ST_DIV_WAIT: begin
				if (it_stat.done) begin
					mean_q <= (|it_quotient[DW-1:MEAN_W]) ? {MEAN_W{1'b1}}
					                                     : it_quotient[MEAN_W-1:0];
				end
			end
			ST_SCALE: begin
				neg_q <= diff_neg;
			end
			ST_FIN: begin
				if (out_free) begin
					load_q     <= load_d;
					mean_out_q <= acc_fault ? '0 : mean_q;
					fault_q    <= acc_fault;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = valid_q;
	assign load         = load_q;
	assign mean_counts  = mean_out_q;
	assign fault        = fault_q;

endmodule

@@ design/tmls_checker.sv @@
// ----------------------------------------------------------------------------
// tmls_checker
// Port-level checks for the trimmed-mean load scaler, bound to the top level.
// ----------------------------------------------------------------------------
module tmls_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 sample_valid,
	input logic                                 sample_stall,
	input logic                                 result_valid,
	input logic                                 result_stall,
	input logic signed [tmls_pkg::LOAD_W-1:0]   load,
	input logic [tmls_pkg::MEAN_W-1:0]          mean_counts,
	input logic                                 fault
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(load) && $stable(mean_counts) && $stable(fault))
		else $error("stalled result beat changed");

	a_fault_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && fault |-> (load == tmls_pkg::LOAD_FAULT) && (mean_counts == '0))
		else $error("fault result carries wrong load or mean");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_stall))
		else $error("result appeared without block processing");

	a_stall_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sample_stall) |-> $past(sample_valid))
		else $error("sample stall rose without a sample beat");

endmodule

bind trimmed_mean_load_scaler tmls_checker u_tmls_checker (.*);
